FILE: src/qs_pkg.sv
`timescale 1ns / 1ps
// Shared constants and sequencer state type for the quicksort sorter.
package qs_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int VALUE_BITS_DEF = 32;
	localparam int OUT_BITS       = 32;

	typedef enum logic [4:0] {
		S_FILL,
		S_START,
		S_PIV,
		S_PIVW,
		S_RD,
		S_CMP,
		S_WR2,
		S_FRD,
		S_FW1,
		S_FW2,
		S_PUSH1,
		S_PUSH2,
		S_POP,
		S_POPW,
		S_OREAD,
		S_OLOAD,
		S_OWAIT
	} qs_state_t;

endpackage

FILE: src/qs_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sorter's input and result words.
interface qs_in_if #(
	parameter int VALUE_BITS = qs_pkg::VALUE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] in_value;
	logic                  in_last;

	modport source (output valid, output in_value, output in_last, input ready);
	modport sink   (input valid, input in_value, input in_last, output ready);
endinterface

interface qs_out_if;
	logic                        valid;
	logic                        ready;
	logic [qs_pkg::OUT_BITS-1:0] out_value;
	logic                        out_last;
	logic                        overflow;

	modport source (output valid, output out_value, output out_last, output overflow,
		input ready);
	modport sink   (input valid, input out_value, input out_last, input overflow,
		output ready);
endinterface

FILE: src/qs_value_mem.sv
`timescale 1ns / 1ps
// Value store: one write port, two registered read ports.
module qs_value_mem #(
	parameter int DEPTH      = qs_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = qs_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(DEPTH)-1:0]      waddr,
	input  logic [VALUE_BITS-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0]      raddr_a,
	input  logic [$clog2(DEPTH)-1:0]      raddr_b,
	output logic [VALUE_BITS-1:0]         rdata_a,
	output logic [VALUE_BITS-1:0]         rdata_b
);
	import qs_pkg::*;

	logic [VALUE_BITS-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

FILE: src/qs_range_stack.sv
`timescale 1ns / 1ps
// Range stack memory: pending low/high index pairs, registered read.
module qs_range_stack #(
	parameter int DEPTH = qs_pkg::DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(DEPTH)-1:0]       waddr,
	input  logic [2*$clog2(DEPTH)-1:0]     wdata,
	input  logic [$clog2(DEPTH)-1:0]       raddr,
	output logic [2*$clog2(DEPTH)-1:0]     rdata
);
	import qs_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);

	logic [2*IDX_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/quicksort_sorter.sv
`timescale 1ns / 1ps
// Quicksort batch sorter: collects a batch, sorts it in place, streams it out.
//
// in_ch takes one word per cycle while collecting: in_value and in_last.
// The word with in_last closes the batch. Up to DEPTH words are stored;
// surplus words are dropped and every result of that batch has overflow set.
// After the closing word in_ch.ready stays low until the last result is taken.
// The sort is a Lomuto quicksort run by one sequencer around a single signed
// comparator, a value memory with two read ports and one write port, and a
// stack memory of pending index ranges. A compare step that swaps makes two
// writes through the single write port. Each range also takes a pivot fetch,
// a final swap, pushes and a pop.
// Results leave from an output register, one word at a time: the next word is
// read only after the previous one is taken; the final one carries out_last.
// A stalled receiver holds the word and the sequencer.
// Reset returns to collecting with an empty batch; no clearing pass is needed.
module quicksort_sorter #(
	parameter int DEPTH      = qs_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = qs_pkg::VALUE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	qs_in_if.sink     in_ch,
	qs_out_if.source  out_ch
);
	import qs_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	qs_state_t state_q, state_d;

	logic [CNT_W-1:0]      fill_q;
	logic [CNT_W-1:0]      sp_q;
	logic                  ovf_q;

	logic [IDX_W-1:0]      lo_q, hi_q, j_q, slot_q, k_q;
	logic [VALUE_BITS-1:0] piv_q, swap_q;
	logic [OUT_BITS-1:0]   out_value_q;
	logic                  out_last_q;
	logic                  out_ovf_q;

	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr, raddr_a, raddr_b;
	logic [VALUE_BITS-1:0] mem_wdata, rdata_a, rdata_b;

	logic                  stk_we;
	logic [IDX_W-1:0]      stk_waddr, stk_raddr;
	logic [2*IDX_W-1:0]    stk_wdata, stk_rdata;

	logic                  in_acc;
	logic                  has_room;
	logic                  stk_room;
	logic                  le_piv;
	logic                  j_end;
	logic                  right_ok;
	logic                  left_ok;
	logic [CNT_W-1:0]      sp_dec;
	logic [CNT_W-1:0]      fill_dec;
	logic [VALUE_BITS+OUT_BITS-1:0] ext_value;

	assign in_acc    = in_ch.valid && (state_q == S_FILL);
	assign has_room  = fill_q < CNT_W'(DEPTH);
	assign stk_room  = sp_q < CNT_W'(DEPTH);
	assign le_piv    = $signed(rdata_a) <= $signed(piv_q);
	assign j_end     = ({1'b0, j_q} + (IDX_W+1)'(1)) == {1'b0, hi_q};
	assign right_ok  = ({1'b0, slot_q} + (IDX_W+1)'(1)) < {1'b0, hi_q};
	assign left_ok   = {1'b0, slot_q} > ({1'b0, lo_q} + (IDX_W+1)'(1));
	assign sp_dec    = sp_q - CNT_W'(1);
	assign fill_dec  = fill_q - CNT_W'(1);
	assign ext_value = {{OUT_BITS{1'b0}}, rdata_a};

	assign in_ch.ready      = (state_q == S_FILL);
	assign out_ch.valid     = (state_q == S_OWAIT);
	assign out_ch.out_value = out_value_q;
	assign out_ch.out_last  = out_last_q;
	assign out_ch.overflow  = out_ovf_q;

	qs_value_mem #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_value_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	qs_range_stack #(
		.DEPTH (DEPTH)
	) u_range_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = fill_q[IDX_W-1:0];
		mem_wdata = in_ch.in_value;
		raddr_a   = hi_q;
		raddr_b   = slot_q;
		stk_we    = 1'b0;
		stk_waddr = sp_q[IDX_W-1:0];
		stk_wdata = {slot_q + IDX_W'(1), hi_q};
		stk_raddr = sp_dec[IDX_W-1:0];
		unique case (state_q)
			S_FILL: begin
				if (in_ch.valid) begin
					mem_we = has_room;
					if (in_ch.in_last) begin
						state_d = S_START;
					end
				end
			end
			S_START: begin
				state_d = (fill_q < CNT_W'(2)) ? S_OREAD : S_PIV;
			end
			S_PIV: begin
				raddr_a = hi_q;
				state_d = S_PIVW;
			end
			S_PIVW: begin
				state_d = S_RD;
			end
			S_RD: begin
				raddr_a = j_q;
				raddr_b = slot_q;
				state_d = S_CMP;
			end
			S_CMP: begin
				if (le_piv) begin
					mem_we    = 1'b1;
					mem_waddr = slot_q;
					mem_wdata = rdata_a;
					state_d   = S_WR2;
				end else begin
					state_d = j_end ? S_FRD : S_RD;
				end
			end
			S_WR2: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
				mem_wdata = swap_q;
				state_d   = j_end ? S_FRD : S_RD;
			end
			S_FRD: begin
				raddr_a = slot_q;
				state_d = S_FW1;
			end
			S_FW1: begin
				mem_we    = 1'b1;
				mem_waddr = hi_q;
				mem_wdata = rdata_a;
				state_d   = S_FW2;
			end
			S_FW2: begin
				mem_we    = 1'b1;
				mem_waddr = slot_q;
				mem_wdata = piv_q;
				state_d   = S_PUSH1;
			end
			S_PUSH1: begin
				stk_we    = right_ok && stk_room;
				stk_wdata = {slot_q + IDX_W'(1), hi_q};
				state_d   = S_PUSH2;
			end
			S_PUSH2: begin
				stk_we    = left_ok && stk_room;
				stk_wdata = {lo_q, slot_q - IDX_W'(1)};
				state_d   = S_POP;
			end
			S_POP: begin
				stk_raddr = sp_dec[IDX_W-1:0];
				state_d   = (sp_q == '0) ? S_OREAD : S_POPW;
			end
			S_POPW: begin
				state_d = S_PIV;
			end
			S_OREAD: begin
				raddr_a = k_q;
				state_d = S_OLOAD;
			end
			S_OLOAD: begin
				state_d = S_OWAIT;
			end
			S_OWAIT: begin
				if (out_ch.ready) begin
					state_d = out_last_q ? S_FILL : S_OREAD;
				end
			end
			default: begin
				state_d = S_FILL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			sp_q   <= '0;
			ovf_q  <= 1'b0;
		end else begin
			if (in_acc) begin
				if (has_room) begin
					fill_q <= fill_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == S_START) begin
				sp_q <= '0;
			end else if (stk_we) begin
				sp_q <= sp_q + CNT_W'(1);
			end else if (state_q == S_POP && sp_q != '0) begin
				sp_q <= sp_dec;
			end
			if (state_q == S_OWAIT && out_ch.ready && out_last_q) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_START: begin
				lo_q <= '0;
				hi_q <= fill_dec[IDX_W-1:0];
				k_q  <= '0;
			end
			S_PIVW: begin
				piv_q  <= rdata_a;
				j_q    <= lo_q;
				slot_q <= lo_q;
			end
			S_CMP: begin
				if (le_piv) begin
					swap_q <= rdata_b;
					slot_q <= slot_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end
			S_WR2: begin
				j_q <= j_q + IDX_W'(1);
			end
			S_POP: begin
				k_q <= '0;
			end
			S_POPW: begin
				{lo_q, hi_q} <= stk_rdata;
			end
			S_OLOAD: begin
				out_value_q <= ext_value[OUT_BITS-1:0];
				out_last_q  <= (CNT_W'(k_q) + CNT_W'(1)) == fill_q;
				out_ovf_q   <= ovf_q;
			end
			S_OWAIT: begin
				if (out_ch.ready && !out_last_q) begin
					k_q <= k_q + IDX_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule
